// ----- rtl/fdsu_pkg.sv -----
// Package: opcodes, status codes and sequencer states for the FORTH data stack unit.
package fdsu_pkg;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_POP = 5'd1, OP_PEEK = 5'd2, OP_DUP = 5'd3, OP_SWAP = 5'd4,
    OP_OVER = 5'd5, OP_ROT = 5'd6, OP_2SWAP = 5'd7, OP_2DUP = 5'd8, OP_2OVER = 5'd9,
    OP_2DROP = 5'd10, OP_ADD = 5'd11, OP_SUB = 5'd12, OP_MUL = 5'd13, OP_DIV = 5'd14,
    OP_DIVMOD = 5'd15, OP_MOD = 5'd16, OP_LT = 5'd17, OP_EQ = 5'd18, OP_GT = 5'd19,
    OP_LE = 5'd20, OP_GE = 5'd21
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_MUL, S_DIV, S_DFIX, S_WRITE, S_TOP, S_TOPW, S_DONE
  } state_t;

  // entries needed on the stack
  function automatic logic [2:0] need_of(input logic [4:0] op);
    case (op)
      OP_PUSH: need_of = 3'd0;
      OP_POP, OP_PEEK, OP_DUP: need_of = 3'd1;
      OP_ROT: need_of = 3'd3;
      OP_2SWAP, OP_2OVER: need_of = 3'd4;
      default: need_of = (op > OP_GE) ? 3'd0 : 3'd2;
    endcase
  endfunction

  // entries added on success (growing words only)
  function automatic logic [1:0] grow_of(input logic [4:0] op);
    case (op)
      OP_PUSH, OP_DUP, OP_OVER: grow_of = 2'd1;
      OP_2DUP, OP_2OVER: grow_of = 2'd2;
      default: grow_of = 2'd0;
    endcase
  endfunction

endpackage

// ----- rtl/fdsu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fdsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/forth_data_stack_unit.sv -----
// Top level of the FORTH data stack unit: sequencer, divider and stack memory.
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | opcode, push_value
//  out_    | output    | valid / stall  | status, out_value, entry_count
//  cfg_    | input     | valid / ready  | data (stack_limit)
//
// One transaction at a time. Operands are read from the stack RAM one entry a
// cycle (one read port), results are written back one entry a cycle, then the
// new top is read back. div, mod and divmod with a nonzero divisor pass through
// the restoring divider, and mul through a registered multiplier. After a result
// is taken the block returns to idle before the next input is accepted.
// Reset (rst_n low, synchronous) empties the stack and sets the limit to 64;
// memory contents are left as they are. A stalled result holds in the output
// register; the input is stalled until the result is taken.
module forth_data_stack_unit
  import fdsu_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_opcode,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_out_value,
  output logic [6:0]         out_entry_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DCW = $clog2(WORD_BITS + 1);

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // stack count
  logic [6:0]    lim_r;
  logic [4:0]    op_r, op_nxt;
  logic [WORD_BITS-1:0] pv_r, pv_nxt;
  // operands: o_r[k] = entry at depth k+1 from top
  logic [WORD_BITS-1:0] o_r [4];
  logic [WORD_BITS-1:0] o_nxt [4];
  // results to write: w_r[k] written at depth k+1 of the new stack
  logic [WORD_BITS-1:0] w_r [4];
  logic [WORD_BITS-1:0] w_nxt [4];
  logic [2:0] ridx_r, ridx_nxt, nrd_r, nrd_nxt;
  logic [2:0] widx_r, widx_nxt, nwr_r, nwr_nxt;
  logic       rvld_r, rvld_nxt;        // read data arriving this cycle
  logic [2:0] rtag_r, rtag_nxt;
  logic [CW-1:0] ncnt_r, ncnt_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic [WORD_BITS-1:0] oval_r, oval_nxt;
  logic       popped_r, popped_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  // divider
  logic [WORD_BITS-1:0] dq_r, dq_nxt, drem_r, drem_nxt, dd_r, dd_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [WORD_BITS-1:0] prod_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  fdsu_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // effective limit = min(stack_limit, STACK_DEPTH)
  logic [CW:0] lim_eff;
  assign lim_eff = (int'(lim_r) > STACK_DEPTH) ? (CW+1)'(STACK_DEPTH)
                                                : (CW+1)'(lim_r);

  logic [WORD_BITS-1:0] a_w, b_w, ma_w, mb_w, rsub_w, q_s, r_s;
  logic                 lt_w;
  logic [WORD_BITS:0]   trial_w;
  assign b_w  = o_r[0];
  assign a_w  = o_r[1];
  assign ma_w = a_w[WORD_BITS-1] ? -a_w : a_w;
  assign mb_w = b_w[WORD_BITS-1] ? -b_w : b_w;
  assign lt_w = $signed(a_w) < $signed(b_w);
  assign trial_w = {drem_r, dq_r[WORD_BITS-1]} - {1'b0, dd_r};
  assign rsub_w = trial_w[WORD_BITS-1:0];
  assign q_s = (a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1]) ? -dq_r : dq_r;
  assign r_s = a_w[WORD_BITS-1] ? -drem_r : drem_r;

  // only the low word of the product is kept
  always_ff @(posedge clk) begin
    prod_r <= a_w * b_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      lim_r <= 7'd64;
      rvld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      rvld_r <= rvld_nxt;
      if (cfg_valid && cfg_ready) lim_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; pv_r <= pv_nxt;
    ridx_r <= ridx_nxt; nrd_r <= nrd_nxt; widx_r <= widx_nxt; nwr_r <= nwr_nxt;
    rtag_r <= rtag_nxt; ncnt_r <= ncnt_nxt; ostat_r <= ostat_nxt;
    oval_r <= oval_nxt; popped_r <= popped_nxt; ocnt_r <= ocnt_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dd_r <= dd_nxt; dcnt_r <= dcnt_nxt;
    for (int k = 0; k < 4; k++) begin
      o_r[k] <= o_nxt[k];
      w_r[k] <= w_nxt[k];
    end
  end

  assign cfg_ready = (st_r == S_IDLE);
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_status = ostat_r;
  assign out_out_value = 32'(signed'(oval_r));
  assign out_entry_count = 7'(ocnt_r);

  always_comb begin
    logic [2:0] need;
    logic [1:0] grow;
    st_nxt = st_r; cnt_nxt = cnt_r; op_nxt = op_r; pv_nxt = pv_r;
    ridx_nxt = ridx_r; nrd_nxt = nrd_r; widx_nxt = widx_r; nwr_nxt = nwr_r;
    rvld_nxt = 1'b0; rtag_nxt = rtag_r; ncnt_nxt = ncnt_r; ostat_nxt = ostat_r;
    oval_nxt = oval_r; popped_nxt = popped_r; ocnt_nxt = ocnt_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dd_nxt = dd_r; dcnt_nxt = dcnt_r;
    for (int k = 0; k < 4; k++) begin
      o_nxt[k] = o_r[k];
      w_nxt[k] = w_r[k];
    end
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = w_r[widx_r[1:0]];
    ram_raddr = '0;
    need = need_of(op_r);
    grow = grow_of(op_r);

    // capture arriving read data
    if (rvld_r) o_nxt[rtag_r[1:0]] = ram_rdata;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          pv_nxt = WORD_BITS'(signed'(in_push_value));
          popped_nxt = 1'b0;
          st_nxt = S_READ;
        end
      end
      S_READ: begin
        // check for underflow and overflow; operand reads are issued one per cycle in S_LOAD
        if ({1'b0, cnt_r} < (CW+1)'(need)) begin
          ostat_nxt = ST_UNDER; ncnt_nxt = cnt_r; st_nxt = S_TOP;
        end else if (grow != 2'd0 &&
                     ({1'b0, cnt_r} + (CW+1)'(grow)) > lim_eff) begin
          ostat_nxt = ST_OVER; ncnt_nxt = cnt_r; st_nxt = S_TOP;
        end else begin
          ostat_nxt = ST_OK; ridx_nxt = 3'd0; nrd_nxt = need;
          st_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (ridx_r < nrd_r) begin
          ram_raddr = AW'(cnt_r - CW'(ridx_r) - CW'(1));
          rvld_nxt = 1'b1; rtag_nxt = ridx_r;
          ridx_nxt = ridx_r + 3'd1;
        end else if (!rvld_r) begin
          // all operands in o_r: form results
          widx_nxt = 3'd0;
          case (op_r)
            OP_PUSH: begin w_nxt[0] = pv_r; nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r + CW'(1); end
            OP_POP: begin nwr_nxt = 3'd0; oval_nxt = o_r[0]; popped_nxt = 1'b1;
              ncnt_nxt = cnt_r - CW'(1); end
            OP_DUP: begin w_nxt[0] = o_r[0]; nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r + CW'(1); end
            OP_SWAP: begin w_nxt[0] = o_r[1]; w_nxt[1] = o_r[0]; nwr_nxt = 3'd2;
              ncnt_nxt = cnt_r; end
            OP_OVER: begin w_nxt[0] = o_r[1]; nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r + CW'(1); end
            OP_ROT: begin w_nxt[0] = o_r[2]; w_nxt[1] = o_r[0]; w_nxt[2] = o_r[1];
              nwr_nxt = 3'd3; ncnt_nxt = cnt_r; end
            OP_2SWAP: begin w_nxt[0] = o_r[2]; w_nxt[1] = o_r[3];
              w_nxt[2] = o_r[0]; w_nxt[3] = o_r[1]; nwr_nxt = 3'd4;
              ncnt_nxt = cnt_r; end
            OP_2DUP: begin w_nxt[0] = o_r[0]; w_nxt[1] = o_r[1]; nwr_nxt = 3'd2;
              ncnt_nxt = cnt_r + CW'(2); end
            OP_2OVER: begin w_nxt[0] = o_r[2]; w_nxt[1] = o_r[3]; nwr_nxt = 3'd2;
              ncnt_nxt = cnt_r + CW'(2); end
            OP_2DROP: begin nwr_nxt = 3'd0; ncnt_nxt = cnt_r - CW'(2); end
            OP_ADD: begin w_nxt[0] = a_w + b_w; nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r - CW'(1); end
            OP_SUB: begin w_nxt[0] = a_w - b_w; nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r - CW'(1); end
            OP_LT: begin w_nxt[0] = WORD_BITS'(lt_w); nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r - CW'(1); end
            OP_EQ: begin w_nxt[0] = WORD_BITS'(a_w == b_w); nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r - CW'(1); end
            OP_GT: begin w_nxt[0] = WORD_BITS'(!lt_w && a_w != b_w);
              nwr_nxt = 3'd1; ncnt_nxt = cnt_r - CW'(1); end
            OP_LE: begin w_nxt[0] = WORD_BITS'(lt_w || a_w == b_w);
              nwr_nxt = 3'd1; ncnt_nxt = cnt_r - CW'(1); end
            OP_GE: begin w_nxt[0] = WORD_BITS'(!lt_w); nwr_nxt = 3'd1;
              ncnt_nxt = cnt_r - CW'(1); end
            default: begin nwr_nxt = 3'd0; ncnt_nxt = cnt_r; end // peek, unused
          endcase
          if (op_r == OP_MUL) begin
            ncnt_nxt = cnt_r - CW'(1); st_nxt = S_MUL;
          end else if (op_r == OP_DIV || op_r == OP_DIVMOD || op_r == OP_MOD) begin
            if (b_w == '0) begin
              ostat_nxt = ST_DIVZ; nwr_nxt = 3'd0; ncnt_nxt = cnt_r - CW'(2);
              st_nxt = S_WRITE;
            end else begin
              dq_nxt = ma_w; dd_nxt = mb_w; drem_nxt = '0;
              dcnt_nxt = DCW'(WORD_BITS); st_nxt = S_DIV;
            end
          end else begin
            st_nxt = S_WRITE;
          end
        end
      end
      S_MUL: begin
        w_nxt[0] = prod_r; nwr_nxt = 3'd1; st_nxt = S_WRITE;
      end
      S_DIV: begin
        // restoring divider, one quotient bit per cycle
        if (!trial_w[WORD_BITS]) begin
          drem_nxt = rsub_w; dq_nxt = {dq_r[WORD_BITS-2:0], 1'b1};
        end else begin
          drem_nxt = {drem_r[WORD_BITS-2:0], dq_r[WORD_BITS-1]};
          dq_nxt = {dq_r[WORD_BITS-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) st_nxt = S_DFIX;
      end
      S_DFIX: begin
        case (op_r)
          OP_DIVMOD: begin w_nxt[0] = q_s; w_nxt[1] = r_s; nwr_nxt = 3'd2;
            ncnt_nxt = cnt_r; end
          OP_DIV: begin w_nxt[0] = q_s; nwr_nxt = 3'd1; ncnt_nxt = cnt_r - CW'(1); end
          default: begin w_nxt[0] = r_s; nwr_nxt = 3'd1;
            ncnt_nxt = cnt_r - CW'(1); end
        endcase
        st_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (widx_r < nwr_r) begin
          ram_we = 1'b1;
          ram_waddr = AW'(ncnt_r - CW'(widx_r) - CW'(1));
          widx_nxt = widx_r + 3'd1;
        end else begin
          st_nxt = S_TOP;
        end
      end
      S_TOP: begin
        cnt_nxt = ncnt_r;
        ocnt_nxt = ncnt_r;
        ram_raddr = AW'(ncnt_r - CW'(1));
        st_nxt = S_TOPW;
      end
      S_TOPW: begin
        if (!popped_r) oval_nxt = (ocnt_r == '0) ? '0 : ram_rdata;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // stack never exceeds its depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  // count only changes on the way to a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (st_r == S_TOPW))
    else $error("count changed outside commit");
  // a held result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_out_value)))
    else $error("result lost under stall");
  // no memory write while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !ram_we)
    else $error("write while idle");
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the FORTH data stack unit: stack predictor, scoreboard, drivers.
`timescale 1ns / 100ps

class stack_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  count;
  } answer_t;

  logic [31:0] words [64];
  int unsigned depth;
  int unsigned limit;
  answer_t     pending [$];
  int          errors;

  function void clear();
    depth = 0;
    limit = 64;
    pending.delete();
    errors = 0;
  endfunction

  function void set_limit(logic [6:0] v);
    limit = v;
  endfunction

  function automatic int unsigned needs(fdsu_pkg::opcode_t op);
    case (op)
      fdsu_pkg::OP_PUSH: return 0;
      fdsu_pkg::OP_POP, fdsu_pkg::OP_PEEK, fdsu_pkg::OP_DUP: return 1;
      fdsu_pkg::OP_ROT: return 3;
      fdsu_pkg::OP_2SWAP, fdsu_pkg::OP_2OVER: return 4;
      default: return 2;
    endcase
  endfunction

  function automatic int grows(fdsu_pkg::opcode_t op);
    case (op)
      fdsu_pkg::OP_PUSH, fdsu_pkg::OP_DUP, fdsu_pkg::OP_OVER: return 1;
      fdsu_pkg::OP_2DUP, fdsu_pkg::OP_2OVER: return 2;
      default: return 0;
    endcase
  endfunction

  // note an accepted input transaction and queue its expected result
  function void note_input(logic [4:0] code, logic [31:0] pv);
    fdsu_pkg::opcode_t op;
    int unsigned lim;
    logic [1:0]  st;
    logic [31:0] a, b, q, r, outv, ma, mb;
    bit          popped;
    answer_t     ans;
    op = fdsu_pkg::opcode_t'(code);
    lim = (limit < 64) ? limit : 64;
    st = fdsu_pkg::ST_OK;
    popped = 0;
    outv = 0;
    if (code <= fdsu_pkg::OP_GE) begin
      if (depth < needs(op)) begin
        st = fdsu_pkg::ST_UNDER;
      end else if (grows(op) > 0 && depth + grows(op) > lim) begin
        st = fdsu_pkg::ST_OVER;
      end else if ((op inside {fdsu_pkg::OP_DIV, fdsu_pkg::OP_DIVMOD, fdsu_pkg::OP_MOD})
                   && words[depth-1] == 0) begin
        depth -= 2;
        st = fdsu_pkg::ST_DIVZ;
      end else begin
        b = words[depth-1];
        a = (depth >= 2) ? words[depth-2] : 0;
        case (op)
          fdsu_pkg::OP_PUSH: begin
            words[depth] = pv;
            depth++;
          end
          fdsu_pkg::OP_POP: begin
            outv = b;
            popped = 1;
            depth--;
          end
          fdsu_pkg::OP_PEEK: ;
          fdsu_pkg::OP_DUP: begin
            words[depth] = b;
            depth++;
          end
          fdsu_pkg::OP_SWAP: begin
            words[depth-1] = a;
            words[depth-2] = b;
          end
          fdsu_pkg::OP_OVER: begin
            words[depth] = a;
            depth++;
          end
          fdsu_pkg::OP_ROT: begin
            q = words[depth-3];
            words[depth-3] = a;
            words[depth-2] = b;
            words[depth-1] = q;
          end
          fdsu_pkg::OP_2SWAP: begin
            q = words[depth-4];
            r = words[depth-3];
            words[depth-4] = a;
            words[depth-3] = b;
            words[depth-2] = q;
            words[depth-1] = r;
          end
          fdsu_pkg::OP_2DUP: begin
            words[depth] = a;
            words[depth+1] = b;
            depth += 2;
          end
          fdsu_pkg::OP_2OVER: begin
            words[depth] = words[depth-4];
            words[depth+1] = words[depth-3];
            depth += 2;
          end
          fdsu_pkg::OP_2DROP: depth -= 2;
          fdsu_pkg::OP_DIV, fdsu_pkg::OP_DIVMOD, fdsu_pkg::OP_MOD: begin
            // truncating division on magnitudes, then fix signs
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            if (a[31] ^ b[31]) q = -q;
            if (a[31]) r = -r;
            if (op == fdsu_pkg::OP_DIVMOD) begin
              words[depth-2] = r;
              words[depth-1] = q;
            end else begin
              depth--;
              words[depth-1] = (op == fdsu_pkg::OP_DIV) ? q : r;
            end
          end
          default: begin
            case (op)
              fdsu_pkg::OP_ADD: q = a + b;
              fdsu_pkg::OP_SUB: q = a - b;
              fdsu_pkg::OP_MUL: q = a * b;
              fdsu_pkg::OP_LT:  q = ($signed(a) < $signed(b));
              fdsu_pkg::OP_EQ:  q = (a == b);
              fdsu_pkg::OP_GT:  q = ($signed(a) > $signed(b));
              fdsu_pkg::OP_LE:  q = ($signed(a) <= $signed(b));
              default:          q = ($signed(a) >= $signed(b));
            endcase
            depth--;
            words[depth-1] = q;
          end
        endcase
      end
    end
    if (!popped) outv = (depth > 0) ? words[depth-1] : 0;
    ans.status = st;
    ans.value = outv;
    ans.count = depth[6:0];
    pending.push_back(ans);
  endfunction

  // compare one accepted result against the oldest expectation
  function void check_result(logic [1:0] st, logic [31:0] v, logic [6:0] c);
    answer_t exp_ans;
    if (pending.size() == 0) begin
      $error("result with nothing expected: status=%0d value=%0h count=%0d", st, v, c);
      errors++;
      return;
    end
    exp_ans = pending.pop_front();
    if (st !== exp_ans.status) begin
      $error("status: expected %0d actual %0d", exp_ans.status, st);
      errors++;
    end
    if (v !== exp_ans.value) begin
      $error("out_value: expected %0h actual %0h", exp_ans.value, v);
      errors++;
    end
    if (c !== exp_ans.count) begin
      $error("entry_count: expected %0d actual %0d", exp_ans.count, c);
      errors++;
    end
  endfunction
endclass

module testbench;
  import fdsu_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [4:0] in_opcode = 0;
  logic signed [31:0] in_push_value = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic signed [31:0] out_out_value;
  logic [6:0] out_entry_count;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_data = 0;

  stack_scoreboard sb;
  bit quiet_tail;    // no idling on either side in the last part
  int idle_cycles;   // cycles with no accepted transaction
  int unsigned shadow_depth;  // tracked to steer the random mix

  localparam int IDLE_LIMIT = 4000;

  always #5 clk = ~clk;

  forth_data_stack_unit dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_push_value,
    .out_valid, .out_stall, .out_status, .out_out_value, .out_entry_count,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Result side: check on every accepted transaction, stall in random bursts.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_out_value, out_entry_count);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 0;
      end else if (!quiet_tail && rst_n && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1;
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction at all is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("forth_data_stack_unit verification failed");
      $finish;
    end
  end

  // send one word; occasionally idle first. Valid stays high after the
  // transaction until the next word, an idle gap or a drain replaces it.
  task automatic send_word(input opcode_t op, input logic [31:0] pv);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_push_value <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, pv);
  endtask

  // wait until every expected result is back, plus the block's latency
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_limit(v);
  endtask

  // random word, biased to keep the stack in a useful depth range
  function automatic opcode_t pick_op(int unsigned lim);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (shadow_depth < 4 && k < 55) return OP_PUSH;
    if (shadow_depth + 2 >= lim && k < 40) return opcode_t'($urandom_range(10, 21));
    if (k < 25) return OP_PUSH;
    return opcode_t'($urandom_range(1, 21));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 0;
      4, 5: return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(input int n, input int unsigned lim);
    opcode_t op;
    for (int i = 0; i < n; i++) begin
      op = pick_op(lim);
      // never divide by an unknown value? all entries below depth are written
      send_word(op, pick_value());
      shadow_depth = sb.depth;
    end
  endtask

  initial begin
    int unsigned limits [6];
    sb = new();
    sb.clear();
    idle_cycles = 0;
    quiet_tail = 0;
    shadow_depth = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: underflow on empty, operand order, division corner cases.
    send_word(OP_POP, 0);
    send_word(OP_ADD, 0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_DIVMOD, 0);          // most negative / -1 wraps
    send_word(OP_PUSH, 32'h7FFF_FFFF);
    send_word(OP_PUSH, -7);
    send_word(OP_MOD, 0);             // remainder follows dividend
    send_word(OP_PUSH, 0);
    send_word(OP_DIV, 0);             // divide by zero eats both
    send_word(OP_PUSH, 5);
    send_word(OP_PUSH, 3);
    send_word(OP_SUB, 0);
    send_word(OP_DUP, 0);
    send_word(OP_OVER, 0);
    send_word(OP_ROT, 0);
    send_word(OP_2DUP, 0);
    send_word(OP_2SWAP, 0);
    send_word(OP_2OVER, 0);
    send_word(OP_MUL, 0);
    send_word(OP_LT, 0);
    send_word(OP_PEEK, 0);
    send_word(opcode_t'(5'd31), 32'h5A5A_A5A5);  // unused opcode: no-op
    send_word(OP_2DROP, 0);
    send_word(OP_SWAP, 0);
    shadow_depth = sb.depth;

    // Pause the sender until everything is back, then vary the limit.
    drain();
    limits = '{1, 0, 127, 4, 64, 9};
    foreach (limits[j]) begin
      write_limit(limits[j][6:0]);
      random_phase(120, limits[j] < 64 ? limits[j] : 64);
      send_word(OP_PUSH, pick_value());  // overflow probe at current depth
      shadow_depth = sb.depth;
      drain();
    end
    write_limit(64);
    quiet_tail = 1;
    random_phase(100, 64);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("forth_data_stack_unit verification clean");
    else
      $display("forth_data_stack_unit verification failed");
    $finish;
  end
endmodule
